/* design/signed_int_to_decimal_ascii_core_macros.svh */
// Assertion macros shared by the signed integer to decimal text core.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is held.
`define SIDTA_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled while reset is held.
`define SIDTA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SIDTA_ASSERT(label, clk, rst_n, ante, cons)
`define SIDTA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* design/sidta_pkg.sv */
// Types, character codes and digit helpers for the decimal text core.
`timescale 1ns / 1ps
package sidta_pkg;

    localparam int CHAR_W     = 6;
    localparam int DIGIT_W    = 4;
    localparam int STAGE_BITS = 8;

    typedef logic [CHAR_W-1:0]  t_char;
    typedef logic [DIGIT_W-1:0] t_digit;

    localparam t_char  DIGIT_BASE   = 6'd48;
    localparam t_char  DIGIT_NINE   = 6'd57;
    localparam t_char  MINUS_CHAR   = 6'd45;
    localparam t_digit DABBLE_LIMIT = 4'd5;
    localparam t_digit DABBLE_ADD   = 4'd3;

    // Add three to a digit of five or more before the next left shift.
    function automatic t_digit dabble_adjust(input t_digit d);
        return (d >= DABBLE_LIMIT) ? t_digit'(d + DABBLE_ADD) : d;
    endfunction

    // ASCII code of one decimal digit.
    function automatic t_char digit_char(input t_digit d);
        return t_char'(DIGIT_BASE + {2'b00, d});
    endfunction

endpackage

/* design/sidta_if.sv */
// Valid/ready channel interfaces for the integer input and the character output.
`timescale 1ns / 1ps
interface sidta_in_if #(parameter int VALUE_WIDTH = 32) ();
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value;
    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

interface sidta_out_if ();
    logic                                valid;
    logic                                ready;
    logic [sidta_pkg::CHAR_W-1:0]        character;
    logic                                last;
    modport source (output valid, output character, output last, input ready);
    modport sink (input valid, input character, input last, output ready);
endinterface

/* design/signed_int_to_decimal_ascii_core.sv */
// Top level: signed integer in, decimal ASCII characters out, most significant first.
// An accepted item passes the magnitude, NSTAGE dabble and digit count registers before its
// first character shows. Throughput: one character per cycle while o_out.ready is high; a
// number has 1 to 11 characters at VALUE_WIDTH 32, and NSTAGE + 2 items queue behind it.
// Synchronous active-low reset empties every stage; BCD and magnitude data are not cleared.
`timescale 1ns / 1ps
`include "signed_int_to_decimal_ascii_core_macros.svh"
module signed_int_to_decimal_ascii_core #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    sidta_in_if.sink           i_in,
    sidta_out_if.source        o_out
);

    localparam int NDIG   = (((VALUE_WIDTH - 1) * 1233) >> 12) + 1;
    localparam int NSTAGE = (VALUE_WIDTH + sidta_pkg::STAGE_BITS - 1) / sidta_pkg::STAGE_BITS;
    localparam int PAD_W  = NSTAGE * sidta_pkg::STAGE_BITS;
    localparam int BCD_W  = NDIG * 4;
    localparam int IDX_W  = (NDIG > 1) ? $clog2(NDIG) : 1;

    logic [NSTAGE:0]  st_valid;
    logic [NSTAGE:0]  st_ready;
    logic [NSTAGE:0]  st_neg;
    logic [BCD_W-1:0] st_bcd [NSTAGE+1];
    logic [PAD_W-1:0] st_mag [NSTAGE+1];

    logic                   r_m_valid;
    logic                   r_m_neg;
    logic [PAD_W-1:0]       r_m_mag;
    logic [VALUE_WIDTH-1:0] w_abs;

    logic             r_x_valid;
    logic             r_x_neg;
    logic [BCD_W-1:0] r_x_bcd;
    logic [IDX_W-1:0] r_x_top;
    logic [IDX_W-1:0] n_x_top;
    logic             w_x_ready;
    logic             w_emit_ready;

    logic             w_is_minus;
    logic             w_char_ok;

    // Magnitude stage: two's complement negate, kept unsigned so the most
    // negative value comes out as its full power of two.
    assign w_abs      = i_in.value[VALUE_WIDTH-1] ? (~i_in.value + 1'b1) : i_in.value;
    assign i_in.ready = !r_m_valid || st_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_m_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_m_neg <= i_in.value[VALUE_WIDTH-1];
            r_m_mag <= PAD_W'(w_abs);
        end
    end

    assign st_valid[0] = r_m_valid;
    assign st_neg[0]   = r_m_neg;
    assign st_bcd[0]   = '0;
    assign st_mag[0]   = r_m_mag;

    // Conversion pipeline, one stage per STAGE_BITS magnitude bits.
    for (genvar g = 0; g < NSTAGE; g++) begin : g_dabble
        sidta_dabble #(
            .NDIG  (NDIG),
            .MAG_W (PAD_W)
        ) u_dabble (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (st_valid[g]),
            .o_ready (st_ready[g]),
            .i_neg   (st_neg[g]),
            .i_bcd   (st_bcd[g]),
            .i_mag   (st_mag[g]),
            .o_valid (st_valid[g+1]),
            .i_ready (st_ready[g+1]),
            .o_neg   (st_neg[g+1]),
            .o_bcd   (st_bcd[g+1]),
            .o_mag   (st_mag[g+1])
        );
    end

    // Digit count stage: index of the highest nonzero digit, zero for zero.
    always_comb begin
        n_x_top = '0;
        for (int d = 0; d < NDIG; d++) begin
            if (st_bcd[NSTAGE][d*4 +: 4] != 4'd0) begin
                n_x_top = IDX_W'(d);
            end
        end
    end

    assign w_x_ready        = !r_x_valid || w_emit_ready;
    assign st_ready[NSTAGE] = w_x_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_valid <= 1'b0;
        end else if (w_x_ready) begin
            r_x_valid <= st_valid[NSTAGE];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_x_ready && st_valid[NSTAGE]) begin
            r_x_neg <= st_neg[NSTAGE];
            r_x_bcd <= st_bcd[NSTAGE];
            r_x_top <= n_x_top;
        end
    end

    // Character serializer.
    sidta_emit #(
        .NDIG  (NDIG),
        .IDX_W (IDX_W)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_x_valid),
        .o_ready     (w_emit_ready),
        .i_neg       (r_x_neg),
        .i_bcd       (r_x_bcd),
        .i_top       (r_x_top),
        .o_valid     (o_out.valid),
        .i_ready     (o_out.ready),
        .o_character (o_out.character),
        .o_last      (o_out.last)
    );

    // Character classes used by the checks below.
    assign w_is_minus = (o_out.character == sidta_pkg::MINUS_CHAR);
    assign w_char_ok  = w_is_minus || ((o_out.character >= sidta_pkg::DIGIT_BASE) &&
                                       (o_out.character <= sidta_pkg::DIGIT_NINE));

    // Every character shown is a minus sign or a decimal digit.
    `SIDTA_ASSERT(a_char_range, i_clk, i_rst_n, o_out.valid, w_char_ok)
    // A minus sign is always followed by at least one digit.
    `SIDTA_ASSERT(a_minus_not_last, i_clk, i_rst_n, o_out.valid && w_is_minus, !o_out.last)
    // A number's characters follow one another without a gap.
    `SIDTA_ASSERT_NEXT(a_run_no_gap, i_clk, i_rst_n, o_out.valid && o_out.ready && !o_out.last, o_out.valid)

endmodule

/* design/sidta_dabble.sv */
// One pipeline stage of shift-and-add-three binary to BCD conversion.
`timescale 1ns / 1ps
module sidta_dabble #(
    parameter int NDIG  = 10,
    parameter int MAG_W = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_neg,
    input  logic [NDIG*4-1:0] i_bcd,
    input  logic [MAG_W-1:0]  i_mag,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_neg,
    output logic [NDIG*4-1:0] o_bcd,
    output logic [MAG_W-1:0]  o_mag
);

    localparam int BCD_W = NDIG * 4;

    logic             r_valid;
    logic             r_neg;
    logic [BCD_W-1:0] r_bcd;
    logic [MAG_W-1:0] r_mag;
    logic [BCD_W-1:0] n_bcd;
    logic [MAG_W-1:0] n_mag;

    // Shift STAGE_BITS magnitude bits into the BCD digits, adjusting before each shift.
    always_comb begin
        n_bcd = i_bcd;
        n_mag = i_mag;
        for (int s = 0; s < sidta_pkg::STAGE_BITS; s++) begin
            for (int d = 0; d < NDIG; d++) begin
                n_bcd[d*4 +: 4] = sidta_pkg::dabble_adjust(n_bcd[d*4 +: 4]);
            end
            n_bcd = {n_bcd[BCD_W-2:0], n_mag[MAG_W-1]};
            n_mag = {n_mag[MAG_W-2:0], 1'b0};
        end
    end

    // The stage takes an item when it is empty or its item moves on.
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_neg <= i_neg;
            r_bcd <= n_bcd;
            r_mag <= n_mag;
        end
    end

    assign o_valid = r_valid;
    assign o_neg   = r_neg;
    assign o_bcd   = r_bcd;
    assign o_mag   = r_mag;

endmodule

/* design/sidta_emit.sv */
// Serializer that sends the sign and the significant digits one character per item.
`timescale 1ns / 1ps
module sidta_emit #(
    parameter int NDIG  = 10,
    parameter int IDX_W = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_neg,
    input  logic [NDIG*4-1:0]            i_bcd,
    input  logic [IDX_W-1:0]             i_top,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [sidta_pkg::CHAR_W-1:0] o_character,
    output logic                         o_last
);

    logic                r_busy;
    logic                r_sign;
    logic [IDX_W-1:0]    r_idx;
    sidta_pkg::t_digit   r_dig [NDIG];
    logic                w_last;
    logic                w_take;

    // The minus sign goes first, then digits from the top index down to zero.
    assign w_last      = !r_sign && (r_idx == '0);
    assign w_take      = r_busy && i_ready;
    assign o_valid     = r_busy;
    assign o_last      = w_last;
    assign o_character = r_sign ? sidta_pkg::MINUS_CHAR : sidta_pkg::digit_char(r_dig[r_idx]);

    // A new number loads when idle or as the final character is taken.
    assign o_ready = !r_busy || (i_ready && w_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_sign <= 1'b0;
            r_idx  <= '0;
        end else if (o_ready && i_valid) begin
            r_busy <= 1'b1;
            r_sign <= i_neg;
            r_idx  <= i_top;
        end else if (w_take) begin
            if (r_sign) begin
                r_sign <= 1'b0;
            end else if (w_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx - 1'b1;
            end
        end
    end

    // Digit store, loaded whole with each number.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            for (int d = 0; d < NDIG; d++) begin
                r_dig[d] <= i_bcd[d*4 +: 4];
            end
        end
    end

endmodule

/* verif/decimal_text_checker_pkg.sv */
// Scoreboard that predicts and checks the decimal text of each converted integer.
`timescale 1ns / 1ps
package decimal_text_checker_pkg;

    localparam int VALUE_W = 32;

    // One expected output character and its end-of-number flag.
    typedef struct packed {
        sidta_pkg::t_char character;
        logic             last;
    } t_text_char;

    class decimal_text_checker;

        t_text_char pending_chars[$];
        int         mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        // Prints one mismatch line and counts it.
        task report(input string msg);
            $display("tb: mismatch: %s", msg);
            mismatch_count++;
        endtask

        // Queues the characters of an accepted integer, most significant first.
        function void note_value(input logic signed [VALUE_W-1:0] value);
            logic [VALUE_W-1:0] magnitude;
            sidta_pkg::t_digit  digits[$];
            logic               negative;
            negative = value[VALUE_W-1];
            // Negation wraps, so the most negative value keeps its full magnitude.
            magnitude = negative ? VALUE_W'(-value) : VALUE_W'(value);
            do begin
                digits.push_front(sidta_pkg::t_digit'(magnitude % 10));
                magnitude = magnitude / 10;
            end while (magnitude != 0);
            if (negative) begin
                pending_chars.push_back('{character: sidta_pkg::MINUS_CHAR, last: 1'b0});
            end
            foreach (digits[i]) begin
                pending_chars.push_back('{character: sidta_pkg::t_char'(sidta_pkg::DIGIT_BASE +
                                                     sidta_pkg::t_char'(digits[i])),
                                          last: (i == digits.size() - 1)});
            end
        endfunction

        // Compares one accepted character with the oldest expected one.
        task check_char(input sidta_pkg::t_char character, input logic last);
            t_text_char want;
            if (pending_chars.size() == 0) begin
                report($sformatf("character %0d arrived with nothing expected", character));
                return;
            end
            want = pending_chars.pop_front();
            if (character !== want.character) begin
                report($sformatf("character %0d, expected %0d", character, want.character));
            end
            if (last !== want.last) begin
                report($sformatf("last %0b on character %0d, expected %0b",
                                 last, character, want.last));
            end
        endtask

        function int pending();
            return pending_chars.size();
        endfunction

    endclass

endpackage

/* verif/tb.sv */
// Top-level testbench for the signed integer to decimal ASCII core.
`timescale 1ns / 1ps
module tb;

    localparam int VALUE_W       = decimal_text_checker_pkg::VALUE_W;
    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int ITEMS_PER_PHASE = 38;

    logic i_clk;
    logic i_rst_n;
    int   src_idle_pct;
    int   sink_stall_pct;

    decimal_text_checker_pkg::decimal_text_checker text_sb = new();

    sidta_in_if #(.VALUE_WIDTH(VALUE_W)) in_if ();
    sidta_out_if out_if ();

    signed_int_to_decimal_ascii_core #(
        .VALUE_WIDTH(VALUE_W)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Free-running clock.
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Sends one integer, with a random gap first, and notes it once accepted.
    task automatic send_value(input logic signed [VALUE_W-1:0] value);
        if ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        in_if.valid <= 1'b1;
        in_if.value <= value;
        do @(posedge i_clk); while (!in_if.ready);
        text_sb.note_value(value);
    endtask

    // Holds off the sender until every queued character has come out.
    task automatic wait_for_drain();
        in_if.valid <= 1'b0;
        while (text_sb.pending() != 0) @(posedge i_clk);
    endtask

    // Random integer: half fully random, half with a random digit count and sign.
    function automatic logic signed [VALUE_W-1:0] random_value();
        longint unsigned span;
        longint unsigned magnitude;
        int              ndigits;
        if ($urandom_range(1) == 0) begin
            return $urandom;
        end
        ndigits = $urandom_range(1, 10);
        span = 1;
        repeat (ndigits) span = span * 10;
        magnitude = {$urandom, $urandom} % span;
        return $urandom_range(1) ? -VALUE_W'(magnitude) : VALUE_W'(magnitude);
    endfunction

    // Receiver: checks each accepted character and stalls at random.
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            text_sb.check_char(out_if.character, out_if.last);
        end
        out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Watchdog on cycles in which neither channel moves an item.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("tb: failure");
        $finish;
    end

    // Main stimulus sequence.
    initial begin : stimulus
        logic signed [VALUE_W-1:0] directed[$];
        directed = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99,
                     32'sd100, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000001,
                     32'sd1000000000, 32'sd999999999, -32'sd999999999,
                     32'sd123456789, -32'sd1000000000, 32'sh55555555, 32'shAAAAAAAA,
                     -32'sd5, 32'sd4294967};
        src_idle_pct   = 8;
        sink_stall_pct = 63;
        i_rst_n      <= 1'b0;
        in_if.valid  <= 1'b0;
        in_if.value  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Extremes, zero, sign changes and digit-count boundaries.
        foreach (directed[i]) send_value(directed[i]);
        wait_for_drain();

        // Three idling profiles: slow receiver, slow sender, then full rate.
        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct   = (phase == 0) ? 8 : (phase == 1) ? 63 : 0;
            sink_stall_pct = (phase == 0) ? 63 : (phase == 1) ? 8 : 0;
            repeat (ITEMS_PER_PHASE) send_value(random_value());
            wait_for_drain();
        end

        // Let any stray characters show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (text_sb.pending() != 0) begin
            text_sb.report($sformatf("%0d characters never arrived", text_sb.pending()));
        end
        if (text_sb.mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
